// ===== sv/hrl_pkg.sv =====
// shared types and constants for the http reply length parser
// no dependencies; used by the top level and its port checker
`default_nettype none

package hrl_pkg;

  // parse phase codes as seen on phase_o
  localparam logic [1:0] PHASE_STATUS = 2'd0;
  localparam logic [1:0] PHASE_NAME   = 2'd1;
  localparam logic [1:0] PHASE_VALUE  = 2'd2;
  localparam logic [1:0] PHASE_BODY   = 2'd3;

  // characters the parser reacts to
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // header name to look for, "Content-Length"
  localparam int unsigned KEY_LEN = 14;
  localparam logic [3:0]  KEY_LAST = 4'(KEY_LEN);

  // value saturation limit
  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

  // token characters for codes 0..127, bit n marks code n
  localparam logic [127:0] TCHAR_BITS = {
    32'h57FF_FFFF, 32'hC7FF_FFFE, 32'h03FF_6CFA, 32'h0000_0000
  };

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic token_char(input logic [7:0] c);
    return !c[7] && TCHAR_BITS[c[6:0]];
  endfunction

  // one result item
  typedef struct packed {
    logic [1:0]  phase;
    logic        header_complete;
    logic [31:0] header_length;
    logic [30:0] content_length;
    logic [31:0] reply_length;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/http_reply_length_parser.sv =====
// http reply length parser top level: byte-wise header scanner with result skid
// depends on hrl_pkg
`default_nettype none

// Takes one reply byte per transfer and returns one result per byte showing
// the parser after that byte: phase, header-complete flag, header length,
// the last Content-Length value and the total reply length. A byte with
// start_of_reply_i set restarts the parser before it is handled. Each byte
// is folded into the parser registers in the cycle it is accepted, so the
// block takes one byte every clock while in_stall_o is low; the result is
// registered with it. A two-entry output stage (output register plus skid
// register) keeps input transfers going for one more byte while a result is
// stalled; in_stall_o rises only once both entries are full. Byte and reply
// lengths are LENGTH_BITS wide internally and saturate at all ones; the
// ports carry their low 32 bits. Chunked bodies are not handled: body bytes
// change nothing.
module http_reply_length_parser #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        start_of_reply_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [1:0]  phase_o,
  output      logic        header_complete_o,
  output      logic [31:0] header_length_o,
  output      logic [30:0] content_length_o,
  output      logic [31:0] reply_length_o
);

  localparam int unsigned LB    = LENGTH_BITS;
  // sum wide enough for length plus a 31-bit content length and a carry
  localparam int unsigned SUM_W = ((LB > 31) ? LB : 31) + 1;
  // view of the lengths at least 32 bits wide for the ports
  localparam int unsigned EXT_W = (LB > 32) ? LB : 32;
  localparam logic [LB-1:0] LEN_MAX = '1;

  typedef enum logic [1:0] {
    PH_STATUS = hrl_pkg::PHASE_STATUS,
    PH_NAME   = hrl_pkg::PHASE_NAME,
    PH_VALUE  = hrl_pkg::PHASE_VALUE,
    PH_BODY   = hrl_pkg::PHASE_BODY
  } phase_e;

  typedef enum logic [1:0] {
    VM_SKIP   = 2'd0,
    VM_DIGITS = 2'd1,
    VM_DONE   = 2'd2
  } vmode_e;

  // parser registers
  phase_e         phase_q, phase_d;
  logic [3:0]     match_pos_q, match_pos_d;
  logic           matched_q, matched_d;
  logic           nonempty_q, nonempty_d;
  vmode_e         vmode_q, vmode_d;
  logic           negative_q, negative_d;
  logic [30:0]    acc_q, acc_d;
  logic [LB-1:0]  byte_cnt_q, byte_cnt_d;
  logic [30:0]    content_val_q, content_val_d;
  logic [LB-1:0]  total_len_q, total_len_d;

  // output stage
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  hrl_pkg::result_t  out_q, out_d;
  hrl_pkg::result_t  skid_q, skid_d;
  hrl_pkg::result_t  result;

  logic in_xfer;
  logic out_free;

  // byte classification
  logic [7:0]  c;
  logic        c_lf;
  logic        c_digit;
  logic        c_space;
  logic        c_sign;
  logic [3:0]  pos_eff;
  logic [3:0]  pos_next;
  logic [34:0] acc_mul;
  logic [SUM_W-1:0] reply_sum;
  logic [EXT_W-1:0] cnt_ext;
  logic [EXT_W-1:0] reply_ext;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign c       = data_byte_i;
  assign c_lf    = (c == hrl_pkg::CHAR_LF);
  assign c_digit = (c >= hrl_pkg::CHAR_ZERO) && (c <= hrl_pkg::CHAR_NINE);
  assign c_space = (c == hrl_pkg::CHAR_SPACE) ||
                   ((c >= hrl_pkg::CHAR_TAB) && (c <= hrl_pkg::CHAR_CR));
  assign c_sign  = (c == hrl_pkg::CHAR_PLUS) || (c == hrl_pkg::CHAR_MINUS);

  // next parser state for the byte on the input
  always_comb begin
    // start of a new reply clears everything before the byte is taken
    if (start_of_reply_i) begin
      phase_d       = PH_STATUS;
      match_pos_d   = '0;
      matched_d     = 1'b0;
      nonempty_d    = 1'b0;
      vmode_d       = VM_SKIP;
      negative_d    = 1'b0;
      acc_d         = '0;
      byte_cnt_d    = '0;
      content_val_d = '0;
      total_len_d   = LEN_MAX;
    end else begin
      phase_d       = phase_q;
      match_pos_d   = match_pos_q;
      matched_d     = matched_q;
      nonempty_d    = nonempty_q;
      vmode_d       = vmode_q;
      negative_d    = negative_q;
      acc_d         = acc_q;
      byte_cnt_d    = byte_cnt_q;
      content_val_d = content_val_q;
      total_len_d   = total_len_q;
    end

    // streaming substring match on the name
    pos_eff  = (match_pos_d >= hrl_pkg::KEY_LAST) ? 4'd0 : match_pos_d;
    if (c == hrl_pkg::key_char(pos_eff)) begin
      pos_next = pos_eff + 4'd1;
    end else begin
      pos_next = (c == hrl_pkg::key_char(4'd0)) ? 4'd1 : 4'd0;
    end

    // acc * 10 + digit
    acc_mul = {1'b0, acc_d, 3'b000} + {3'b000, acc_d, 1'b0} + {31'd0, c[3:0]};

    if (phase_d != PH_BODY) begin
      if (byte_cnt_d != LEN_MAX) begin
        byte_cnt_d = byte_cnt_d + LB'(1);
      end
    end

    reply_sum = SUM_W'(byte_cnt_d) + SUM_W'(content_val_d);

    unique case (phase_d)
      PH_STATUS: begin
        if (c_lf) begin
          phase_d = PH_NAME;
        end
      end
      PH_NAME: begin
        if (hrl_pkg::token_char(c)) begin
          nonempty_d = 1'b1;
          if (pos_next == hrl_pkg::KEY_LAST) begin
            matched_d   = 1'b1;
            match_pos_d = '0;
          end else begin
            match_pos_d = pos_next;
          end
        end else if (c == hrl_pkg::CHAR_COLON) begin
          phase_d     = PH_VALUE;
          nonempty_d  = 1'b0;
          match_pos_d = '0;
        end else if (c_lf && !nonempty_d) begin
          // blank line: header done, fix the reply length
          phase_d = PH_BODY;
          if (reply_sum[SUM_W-1:LB] != '0) begin
            total_len_d = LEN_MAX;
          end else begin
            total_len_d = reply_sum[LB-1:0];
          end
        end
      end
      PH_VALUE: begin
        if (c_lf) begin
          if (matched_d) begin
            content_val_d = negative_d ? 31'd0 : acc_d;
          end
          phase_d     = PH_NAME;
          match_pos_d = '0;
          matched_d   = 1'b0;
          nonempty_d  = 1'b0;
          vmode_d     = VM_SKIP;
          negative_d  = 1'b0;
          acc_d       = '0;
        end else begin
          case (vmode_d)
            VM_SKIP: begin
              if (c_sign) begin
                negative_d = (c == hrl_pkg::CHAR_MINUS);
                vmode_d    = VM_DIGITS;
              end else if (c_digit) begin
                vmode_d = VM_DIGITS;
                acc_d   = (acc_mul[34:31] != '0) ? hrl_pkg::VALUE_MAX : acc_mul[30:0];
              end else if (!c_space) begin
                vmode_d = VM_DONE;
              end
            end
            VM_DIGITS: begin
              if (c_digit) begin
                acc_d = (acc_mul[34:31] != '0) ? hrl_pkg::VALUE_MAX : acc_mul[30:0];
              end else begin
                vmode_d = VM_DONE;
              end
            end
            default: begin
              // parse stopped, rest of the value is ignored
            end
          endcase
        end
      end
      PH_BODY: begin
        // body bytes leave everything frozen
      end
      default: begin
      end
    endcase
  end

  // result for the byte being taken
  assign cnt_ext   = EXT_W'(byte_cnt_d);
  assign reply_ext = EXT_W'(total_len_d);

  always_comb begin
    result.phase           = phase_d;
    result.header_complete = (phase_d == PH_BODY);
    result.header_length   = cnt_ext[31:0];
    result.content_length  = content_val_d;
    result.reply_length    = reply_ext[31:0];
  end

  // output register with one skid entry behind it
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = result;
        out_valid_d = in_xfer;
      end
    end else if (in_xfer) begin
      skid_d       = result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_STATUS;
      match_pos_q   <= '0;
      matched_q     <= 1'b0;
      nonempty_q    <= 1'b0;
      vmode_q       <= VM_SKIP;
      negative_q    <= 1'b0;
      acc_q         <= '0;
      byte_cnt_q    <= '0;
      content_val_q <= '0;
      total_len_q   <= LEN_MAX;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_q       <= phase_d;
        match_pos_q   <= match_pos_d;
        matched_q     <= matched_d;
        nonempty_q    <= nonempty_d;
        vmode_q       <= vmode_d;
        negative_q    <= negative_d;
        acc_q         <= acc_d;
        byte_cnt_q    <= byte_cnt_d;
        content_val_q <= content_val_d;
        total_len_q   <= total_len_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o       = out_valid_q;
  assign phase_o           = out_q.phase;
  assign header_complete_o = out_q.header_complete;
  assign header_length_o   = out_q.header_length;
  assign content_length_o  = out_q.content_length;
  assign reply_length_o    = out_q.reply_length;

endmodule

`default_nettype wire

// ===== sv/hrl_checker.sv =====
// port-level checks for the http reply length parser, bound to the top level
// depends on hrl_pkg
`default_nettype none

module hrl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  phase_o,
  input wire logic        header_complete_o,
  input wire logic [30:0] content_length_o,
  input wire logic [31:0] reply_length_o
);

  // complete flag tracks the body phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (header_complete_o == (phase_o == hrl_pkg::PHASE_BODY)))
    else $error("header_complete_o disagrees with phase_o");

  // reply length stays all ones until the header is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !header_complete_o) |-> (reply_length_o == 32'hFFFF_FFFF))
    else $error("reply_length_o set before header end");

  // no content length can be known while still on the status line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (phase_o == hrl_pkg::PHASE_STATUS)) |-> (content_length_o == 31'd0))
    else $error("content_length_o nonzero on status line");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(phase_o) && $stable(content_length_o) &&
       $stable(reply_length_o)))
    else $error("stalled result changed");

  // input side only stalls while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind http_reply_length_parser hrl_checker u_hrl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .phase_o           (phase_o),
  .header_complete_o (header_complete_o),
  .content_length_o  (content_length_o),
  .reply_length_o    (reply_length_o)
);

`default_nettype wire

// ===== tb/sv/http_reply_length_parser_check.sv =====
// port checker for the http reply length parser: tracks byte and result transfers,
// predicts each result and compares it field by field
// depends on hrl_pkg
`timescale 1ns / 100ps

module http_reply_length_parser_check (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        start_of_reply_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [1:0]  phase_i,
  input  wire logic        header_complete_i,
  input  wire logic [31:0] header_length_i,
  input  wire logic [30:0] content_length_i,
  input  wire logic [31:0] reply_length_i,
  output int               mismatches_o,
  output int               pending_o,
  output int               checked_o,
  output int               header_ends_o
);

  typedef enum logic [1:0] {NUM_SKIP, NUM_DIGITS, NUM_DONE} num_mode_e;

  localparam logic [8*hrl_pkg::KEY_LEN-1:0] KEY_TEXT = "Content-Length";

  // parser state as this side sees it
  logic [1:0]  ph;
  logic [3:0]  key_pos;
  logic        key_found;
  logic        name_seen;
  num_mode_e   num_mode;
  logic        num_neg;
  logic [30:0] num_acc;
  logic [31:0] byte_count;
  logic [30:0] content_exp;
  logic [31:0] total_exp;

  hrl_pkg::result_t parse_results_q[$];
  hrl_pkg::result_t due_result;

  function automatic void clear_item();
    key_pos   = '0;
    key_found = 1'b0;
    name_seen = 1'b0;
    num_mode  = NUM_SKIP;
    num_neg   = 1'b0;
    num_acc   = '0;
  endfunction

  function automatic void clear_parser();
    clear_item();
    ph          = hrl_pkg::PHASE_STATUS;
    byte_count  = '0;
    content_exp = '0;
    total_exp   = '1;
  endfunction

  function automatic logic tchar(input logic [7:0] c);
    case (c)
      "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", 8'h60, "|", "~":
        return 1'b1;
      default:
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endcase
  endfunction

  // substring search for the key, restarting on a mismatch
  function automatic void track_key(input logic [7:0] c);
    logic [3:0] p;
    p = key_pos;
    if (p >= hrl_pkg::KEY_LEN) p = '0;
    if (c == KEY_TEXT[8*(hrl_pkg::KEY_LEN-1-p) +: 8]) p = p + 4'd1;
    else p = (c == KEY_TEXT[8*(hrl_pkg::KEY_LEN-1) +: 8]) ? 4'd1 : 4'd0;
    if (p == hrl_pkg::KEY_LEN) begin
      key_found = 1'b1;
      p = '0;
    end
    key_pos = p;
  endfunction

  function automatic void take_value_char(input logic [7:0] c);
    logic        digit;
    logic [34:0] prod;
    digit = (c >= hrl_pkg::CHAR_ZERO && c <= hrl_pkg::CHAR_NINE);
    if (num_mode == NUM_SKIP) begin
      if (c == hrl_pkg::CHAR_SPACE || (c >= hrl_pkg::CHAR_TAB && c <= hrl_pkg::CHAR_CR))
        return;
      if (c == hrl_pkg::CHAR_PLUS || c == hrl_pkg::CHAR_MINUS) begin
        num_neg  = (c == hrl_pkg::CHAR_MINUS);
        num_mode = NUM_DIGITS;
        return;
      end
      num_mode = digit ? NUM_DIGITS : NUM_DONE;
    end
    if (num_mode == NUM_DIGITS) begin
      if (digit) begin
        prod    = 35'(num_acc) * 35'd10 + 35'(c - hrl_pkg::CHAR_ZERO);
        num_acc = (prod > 35'(hrl_pkg::VALUE_MAX)) ? hrl_pkg::VALUE_MAX : prod[30:0];
      end else begin
        num_mode = NUM_DONE;
      end
    end
  endfunction

  function automatic hrl_pkg::result_t parse_byte(input logic [7:0] c, input logic restart);
    hrl_pkg::result_t r;
    logic [32:0]      total;
    if (restart) clear_parser();
    if (ph != hrl_pkg::PHASE_BODY) begin
      if (byte_count != '1) byte_count = byte_count + 32'd1;
      case (ph)
        hrl_pkg::PHASE_STATUS: begin
          if (c == hrl_pkg::CHAR_LF) ph = hrl_pkg::PHASE_NAME;
        end
        hrl_pkg::PHASE_NAME: begin
          if (tchar(c)) begin
            name_seen = 1'b1;
            track_key(c);
          end else if (c == hrl_pkg::CHAR_COLON) begin
            ph        = hrl_pkg::PHASE_VALUE;
            name_seen = 1'b0;
            key_pos   = '0;
          end else if (c == hrl_pkg::CHAR_LF && !name_seen) begin
            total     = {1'b0, byte_count} + 33'(content_exp);
            ph        = hrl_pkg::PHASE_BODY;
            total_exp = total[32] ? '1 : total[31:0];
            header_ends_o++;
          end
        end
        default: begin
          if (c == hrl_pkg::CHAR_LF) begin
            if (key_found) content_exp = num_neg ? '0 : num_acc;
            ph = hrl_pkg::PHASE_NAME;
            clear_item();
          end else begin
            take_value_char(c);
          end
        end
      endcase
    end
    r.phase           = ph;
    r.header_complete = (ph == hrl_pkg::PHASE_BODY);
    r.header_length   = byte_count;
    r.content_length  = content_exp;
    r.reply_length    = total_exp;
    return r;
  endfunction

  // one line per mismatch, then count it
  task automatic note_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%t mismatch on %s after %0d results: got %h want %h",
             $realtime, field, checked_o, got, want);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      parse_results_q.delete();
      mismatches_o  = 0;
      checked_o     = 0;
      header_ends_o = 0;
    end else begin
      // a result leaves only after its byte was taken, so compare first
      if (out_valid_i && !out_stall_i) begin
        if (parse_results_q.size() == 0) begin
          note_mismatch("unexpected result", 32'd0, 32'd0);
        end else begin
          due_result = parse_results_q.pop_front();
          if (phase_i !== due_result.phase)
            note_mismatch("phase", 32'(phase_i), 32'(due_result.phase));
          if (header_complete_i !== due_result.header_complete)
            note_mismatch("header_complete", 32'(header_complete_i),
                          32'(due_result.header_complete));
          if (header_length_i !== due_result.header_length)
            note_mismatch("header_length", header_length_i, due_result.header_length);
          if (content_length_i !== due_result.content_length)
            note_mismatch("content_length", 32'(content_length_i),
                          32'(due_result.content_length));
          if (reply_length_i !== due_result.reply_length)
            note_mismatch("reply_length", reply_length_i, due_result.reply_length);
          checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i)
        parse_results_q.push_back(parse_byte(data_byte_i, start_of_reply_i));
    end
    pending_o = parse_results_q.size();
  end

endmodule

// ===== tb/sv/http_reply_length_parser_test.sv =====
// testbench top for the http reply length parser: clock, reset, reply byte stimulus
// and verdict; checking is done by http_reply_length_parser_check
// depends on hrl_pkg, http_reply_length_parser and http_reply_length_parser_check
`timescale 1ns / 100ps

module http_reply_length_parser_test;

  // clock and reset
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  // byte side, the inputs driven from time zero
  logic [7:0]  data_byte_i = 8'h00;
  logic        start_of_reply_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;

  // result side
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  phase_o;
  logic        header_complete_o;
  logic [31:0] header_length_o;
  logic [30:0] content_length_o;
  logic [31:0] reply_length_o;

  // figures from the checker
  int          mismatches;
  int          pending;
  int          checked;
  int          header_ends;

  // stimulus bookkeeping
  logic        gaps_on = 1'b1;     // random idling on both sides
  logic        fresh_reply = 1'b0; // next byte carries the start flag
  logic        drained_once = 1'b0;
  int          sent_bytes = 0;
  int          replies = 0;

  // header names: the key itself, the key embedded, near misses, wrong case,
  // a restart in the middle of the key, and names that never match
  string       header_names [8] = '{"Content-Length", "X-Content-Length-2",
                                    "Content-Lengt", "CContent-Length",
                                    "content-length", "Content-Content-Length",
                                    "Host", "Length-Content"};
  // leading blanks a value may start with (newline excluded, it ends the value)
  logic [7:0]  blank_chars [5] = '{hrl_pkg::CHAR_SPACE, hrl_pkg::CHAR_TAB, 8'h0B, 8'h0C,
                                   hrl_pkg::CHAR_CR};

  always #6 clk_i = ~clk_i;

  // result side stalls at random, decided once per cycle on the falling edge
  always @(negedge clk_i) out_stall_i <= gaps_on && ($urandom_range(0, 99) < 34);

  http_reply_length_parser u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .data_byte_i       (data_byte_i),
    .start_of_reply_i  (start_of_reply_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .phase_o           (phase_o),
    .header_complete_o (header_complete_o),
    .header_length_o   (header_length_o),
    .content_length_o  (content_length_o),
    .reply_length_o    (reply_length_o)
  );

  http_reply_length_parser_check u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .data_byte_i       (data_byte_i),
    .start_of_reply_i  (start_of_reply_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .phase_i           (phase_o),
    .header_complete_i (header_complete_o),
    .header_length_i   (header_length_o),
    .content_length_i  (content_length_o),
    .reply_length_i    (reply_length_o),
    .mismatches_o      (mismatches),
    .pending_o         (pending),
    .checked_o         (checked),
    .header_ends_o     (header_ends)
  );

  // one byte transfer: optional idle cycles, then hold the byte until taken;
  // valid stays high on return so back-to-back bytes never drop it
  task automatic put_byte(input logic [7:0] c);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 34) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    data_byte_i      <= c;
    start_of_reply_i <= fresh_reply;
    in_valid_i       <= 1'b1;
    fresh_reply = 1'b0;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  // stop sending until every result is back
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
  endtask

  function automatic logic [7:0] any_but_lf();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == hrl_pkg::CHAR_LF) c = hrl_pkg::CHAR_SPACE;
    return c;
  endfunction

  // value: blanks, optional sign, digits (sometimes enough to saturate),
  // sometimes trailing junk, then an optional carriage return and the newline
  task automatic put_value();
    int n;
    repeat ($urandom_range(0, 2)) put_byte(blank_chars[$urandom_range(0, 4)]);
    case ($urandom_range(0, 3))
      0: put_byte(hrl_pkg::CHAR_PLUS);
      1: put_byte(hrl_pkg::CHAR_MINUS);
      default: ;
    endcase
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 5);
    repeat (n) put_byte(hrl_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 3) == 0) begin
      put_byte(any_but_lf());
      repeat ($urandom_range(0, 2)) put_byte(hrl_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 1)) put_byte(hrl_pkg::CHAR_CR);
    put_byte(hrl_pkg::CHAR_LF);
  endtask

  // header line with a name from the list, a random name, or an empty name
  task automatic put_header();
    int   pick;
    logic [7:0] c;
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      put_text(header_names[pick]);
    end else if (pick == 8) begin
      repeat ($urandom_range(1, 6)) begin
        c = 8'($urandom_range(33, 126));
        put_byte(c == hrl_pkg::CHAR_COLON ? 8'h78 : c);
      end
    end
    // stray bytes inside the name: non-token, and a newline after a non-empty name
    case ($urandom_range(0, 7))
      0: put_byte(hrl_pkg::CHAR_SPACE);
      1: put_byte(8'($urandom_range(128, 255)));
      2: if (pick != 9) put_byte(hrl_pkg::CHAR_LF);
      default: ;
    endcase
    put_byte(hrl_pkg::CHAR_COLON);
    put_value();
  endtask

  // a whole reply; about one in ten is cut short before its blank line
  task automatic put_reply();
    fresh_reply = 1'b1;
    replies++;
    repeat ($urandom_range(0, 8)) put_byte(any_but_lf());
    put_byte(hrl_pkg::CHAR_LF);
    repeat ($urandom_range(0, 4)) put_header();
    if ($urandom_range(0, 9) == 0) return;
    if ($urandom_range(0, 1)) put_byte(hrl_pkg::CHAR_CR);
    put_byte(hrl_pkg::CHAR_LF);
    repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extreme bytes in the status line, a high byte in a name, a
    // negative value that clamps to zero, the blank line, and a body byte
    fresh_reply = 1'b1;
    replies++;
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(hrl_pkg::CHAR_LF);
    put_byte(8'h80);
    put_text("Content-Length:\t-5\n");
    put_byte(hrl_pkg::CHAR_LF);
    put_byte(8'hFF);
    hold_until_drained();

    // random replies with some noise; one quiet stretch and one drain midway
    while (sent_bytes < 420) begin
      gaps_on = !(sent_bytes >= 200 && sent_bytes < 300);
      if (!drained_once && sent_bytes >= 350) begin
        hold_until_drained();
        drained_once = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        // loose bytes, sometimes restarting the reply in the middle of anything
        fresh_reply = 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
      end else begin
        put_reply();
      end
    end

    hold_until_drained();
    repeat (16) @(posedge clk_i);

    $display("covered %0d bytes over %0d replies, %0d header ends, %0d results compared",
             sent_bytes, replies, header_ends, checked);
    if (mismatches == 0) begin
      $display("[http_reply_length_parser] OK");
    end else begin
      $display("[http_reply_length_parser] ERROR");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #2_000_000;
    $display("[http_reply_length_parser] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/hrl_pkg.sv
sv/http_reply_length_parser.sv
sv/hrl_checker.sv
tb/sv/http_reply_length_parser_check.sv
tb/sv/http_reply_length_parser_test.sv
